// ===== sv/quaternion_to_euler_macros.svh =====
// ---------------------------------------------------------------------------
// quaternion_to_euler_macros
// assertion shorthands, clocked on aclk
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH

// checked outside reset only
`define QTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked in every cycle, reset included
`define QTE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/qte_pkg.sv =====
// ---------------------------------------------------------------------------
// qte_pkg
// shared constants, tables and types of the quaternion to euler pipeline
// ---------------------------------------------------------------------------
package qte_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int ATAN_LEN         = 24;
    localparam int N_ITER = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
    localparam int CORDIC_LAT  = N_ITER + 1;

    localparam int QW          = 16;
    localparam int AW          = 34;
    localparam int CW          = 36;
    localparam int ZW          = 30;
    localparam int SW          = 31;
    localparam int RW          = 31;
    localparam int NW          = 62;
    localparam int SQRT_STAGES = 31;

    localparam logic signed [AW-1:0] ONE_Q30 = AW'(64'sd1 <<< 30);
    localparam logic [NW-1:0]        RAD_ONE = NW'(64'd1 << 60);

    typedef logic signed [ZW-1:0] angle_t;

    localparam angle_t DEG180 = ZW'(180 * 1048576);

    localparam angle_t ATAN_TAB [ATAN_LEN] = '{
        ZW'(47185920), ZW'(27855475), ZW'(14718068), ZW'(7471121),
        ZW'(3750058),  ZW'(1876857),  ZW'(938658),   ZW'(469357),
        ZW'(234682),   ZW'(117342),   ZW'(58671),    ZW'(29335),
        ZW'(14668),    ZW'(7334),     ZW'(3667),     ZW'(1833),
        ZW'(917),      ZW'(458),      ZW'(229),      ZW'(115),
        ZW'(57),       ZW'(29),       ZW'(14),       ZW'(7)
    };

    typedef struct packed {
        logic signed [AW-1:0] sinr;
        logic signed [AW-1:0] cosr;
        logic signed [AW-1:0] siny;
        logic signed [AW-1:0] cosy;
        logic signed [SW-1:0] sinp;
        logic                 clamp;
        logic                 neg;
    } args_t;

endpackage

// ===== sv/qte_products.sv =====
// ---------------------------------------------------------------------------
// qte_products
// product sums of the quaternion and the pitch square root radicand
// ---------------------------------------------------------------------------
module qte_products (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [qte_pkg::QW-1:0]   in_x,
    input  logic signed [qte_pkg::QW-1:0]   in_y,
    input  logic signed [qte_pkg::QW-1:0]   in_z,
    input  logic signed [qte_pkg::QW-1:0]   in_w,
    output logic                            out_valid,
    output qte_pkg::args_t                  out_args,
    output logic [qte_pkg::NW-1:0]          out_rad
);
    import qte_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [2*QW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [2*QW-1:0] zx_reg, wz_reg, xy_reg, zz_reg;
    logic signed [AW-1:0] sinp_next;
    args_t a2_next, a2_reg, a3_reg, a4_reg;
    logic signed [2*SW-1:0] sq_reg;
    logic [NW-1:0] rad_reg;

    always_comb begin
        sinp_next     = (AW'(wy_reg) - AW'(zx_reg)) <<< 1;
        a2_next.sinr  = (AW'(wx_reg) + AW'(yz_reg)) <<< 1;
        a2_next.cosr  = ONE_Q30 - ((AW'(xx_reg) + AW'(yy_reg)) <<< 1);
        a2_next.siny  = (AW'(wz_reg) + AW'(xy_reg)) <<< 1;
        a2_next.cosy  = ONE_Q30 - ((AW'(yy_reg) + AW'(zz_reg)) <<< 1);
        a2_next.sinp  = SW'(sinp_next);
        a2_next.clamp = (sinp_next >= ONE_Q30) || (sinp_next <= -ONE_Q30);
        a2_next.neg   = sinp_next[AW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            wx_reg  <= in_w * in_x;
            yz_reg  <= in_y * in_z;
            xx_reg  <= in_x * in_x;
            yy_reg  <= in_y * in_y;
            wy_reg  <= in_w * in_y;
            zx_reg  <= in_z * in_x;
            wz_reg  <= in_w * in_z;
            xy_reg  <= in_x * in_y;
            zz_reg  <= in_z * in_z;
            a2_reg  <= a2_next;
            sq_reg  <= a2_reg.sinp * a2_reg.sinp;
            a3_reg  <= a2_reg;
            rad_reg <= RAD_ONE - NW'(sq_reg);
            a4_reg  <= a3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_args  = a4_reg;
    assign out_rad   = rad_reg;

endmodule

// ===== sv/qte_isqrt.sv =====
// ---------------------------------------------------------------------------
// qte_isqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module qte_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [qte_pkg::NW-1:0]      in_rad,
    output logic                        out_valid,
    output logic [qte_pkg::RW-1:0]      out_root
);
    import qte_pkg::*;

    logic          vld_reg  [SQRT_STAGES];
    logic [NW-1:0] rem_reg  [SQRT_STAGES];
    logic [NW-1:0] root_reg [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            localparam logic [NW-1:0] BIT_K = NW'(64'd1 << (2 * (SQRT_STAGES - 1 - k)));
            logic          v_in;
            logic [NW-1:0] n_in, r_in, trial, n_next, r_next;

            if (k == 0) begin : g_first
                assign v_in = in_valid;
                assign n_in = in_rad;
                assign r_in = '0;
            end else begin : g_rest
                assign v_in = vld_reg[k-1];
                assign n_in = rem_reg[k-1];
                assign r_in = root_reg[k-1];
            end

            always_comb begin
                trial = r_in + BIT_K;
                if (n_in >= trial) begin
                    n_next = n_in - trial;
                    r_next = (r_in >> 1) + BIT_K;
                end else begin
                    n_next = n_in;
                    r_next = r_in >> 1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (ce) begin
                    vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k]  <= n_next;
                    root_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1][RW-1:0];

endmodule

// ===== sv/qte_cordic.sv =====
// ---------------------------------------------------------------------------
// qte_cordic
// vectoring cordic pipeline, atan2(y, x) in units of 2^-20 degree
// ---------------------------------------------------------------------------
module qte_cordic (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [qte_pkg::AW-1:0]   in_x,
    input  logic signed [qte_pkg::AW-1:0]   in_y,
    output logic                            out_valid,
    output qte_pkg::angle_t                 out_angle
);
    import qte_pkg::*;

    logic                 pv_reg;
    logic signed [CW-1:0] px_reg, py_reg;
    angle_t               pz_reg;
    logic                 pf_reg;

    logic signed [CW-1:0] px_next, py_next;
    angle_t               pz_next;
    logic                 pf_next;

    logic                 vld_reg [N_ITER];
    logic signed [CW-1:0] x_reg   [N_ITER];
    logic signed [CW-1:0] y_reg   [N_ITER];
    angle_t               z_reg   [N_ITER];
    logic                 frz_reg [N_ITER];

    // quadrant fold and the zero sine case
    always_comb begin
        px_next = CW'(in_x);
        py_next = CW'(in_y);
        pz_next = '0;
        pf_next = 1'b0;
        if (in_y == '0) begin
            pf_next = 1'b1;
            pz_next = in_x[AW-1] ? DEG180 : '0;
        end else if (in_x[AW-1]) begin
            pz_next = (in_y > 0) ? DEG180 : -DEG180;
            px_next = -CW'(in_x);
            py_next = -CW'(in_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (ce) begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            pf_reg <= pf_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N_ITER; i++) begin : g_iter
            logic                 v_in, f_in;
            logic signed [CW-1:0] x_in, y_in, x_next, y_next;
            angle_t               z_in, z_next;

            if (i == 0) begin : g_first
                assign v_in = pv_reg;
                assign x_in = px_reg;
                assign y_in = py_reg;
                assign z_in = pz_reg;
                assign f_in = pf_reg;
            end else begin : g_rest
                assign v_in = vld_reg[i-1];
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign f_in = frz_reg[i-1];
            end

            always_comb begin
                if (y_in > 0) begin
                    x_next = x_in + (y_in >>> i);
                    y_next = y_in - (x_in >>> i);
                    z_next = z_in + ATAN_TAB[i];
                end else begin
                    x_next = x_in - (y_in >>> i);
                    y_next = y_in + (x_in >>> i);
                    z_next = z_in - ATAN_TAB[i];
                end
                if (f_in) begin
                    z_next = z_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (ce) begin
                    vld_reg[i] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    x_reg[i]   <= x_next;
                    y_reg[i]   <= y_next;
                    z_reg[i]   <= z_next;
                    frz_reg[i] <= f_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N_ITER-1];
    assign out_angle = z_reg[N_ITER-1];

endmodule

// ===== sv/quaternion_to_euler.sv =====
// ---------------------------------------------------------------------------
// quaternion_to_euler
// unit quaternion in, roll / pitch / yaw in 1/128 degree out
// ---------------------------------------------------------------------------
// Takes one quaternion per cycle while s_tready is high and returns one
// result per quaternion, in order, after four product stages, a 31 stage
// square root for the pitch cosine, the cordic (one fold stage plus one
// stage per iteration), a rounding stage and the output register. A two
// entry output slice keeps the input open while a result waits, so the
// pipeline only halts once both entries are full.
// Pitch saturates at +/-90 degrees with pitch_clamped set.
// ---------------------------------------------------------------------------
`include "quaternion_to_euler_macros.svh"

module quaternion_to_euler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic [0:0]  m_tuser    // pitch_clamped
);
    import qte_pkg::*;

    localparam int OW = ZW - 13;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } res_t;

    function automatic logic signed [OW-1:0] to_out(angle_t z, logic signed [OW-1:0] lim);
        angle_t               zr;
        logic signed [OW-1:0] v;
        zr = z + ZW'(4096);
        v  = OW'(zr >>> 13);
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

    logic ce;

    logic           prod_valid;
    args_t          prod_args;
    logic [NW-1:0]  prod_rad;

    logic           sq_valid;
    logic [RW-1:0]  sq_root;
    args_t          arg_dl_reg [SQRT_STAGES];
    args_t          arg_d;

    logic [1:0]     flg_dl_reg [CORDIC_LAT];

    logic           ang_valid;
    angle_t         roll_z, yaw_z, pitch_z;

    logic           rnd_valid_reg;
    res_t           rnd_reg, rnd_next;
    res_t           out_reg, skid_reg;
    logic           m_tvalid_reg, skid_full_reg;

    assign ce       = !skid_full_reg;
    assign s_tready = ce;

    qte_products u_products (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .in_z      (s_tdata[47:32]),
        .in_w      (s_tdata[63:48]),
        .out_valid (prod_valid),
        .out_args  (prod_args),
        .out_rad   (prod_rad)
    );

    qte_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (prod_valid),
        .in_rad    (prod_rad),
        .out_valid (sq_valid),
        .out_root  (sq_root)
    );

    // product sums ride alongside the square root
    always_ff @(posedge aclk) begin
        if (ce) begin
            arg_dl_reg[0] <= prod_args;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                arg_dl_reg[k] <= arg_dl_reg[k-1];
            end
        end
    end

    assign arg_d = arg_dl_reg[SQRT_STAGES-1];

    qte_cordic u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_x      (arg_d.cosr),
        .in_y      (arg_d.sinr),
        .out_valid (),
        .out_angle (roll_z)
    );

    qte_cordic u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_x      (arg_d.cosy),
        .in_y      (arg_d.siny),
        .out_valid (),
        .out_angle (yaw_z)
    );

    qte_cordic u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_x      ({{(AW-RW){1'b0}}, sq_root}),
        .in_y      (AW'(arg_d.sinp)),
        .out_valid (ang_valid),
        .out_angle (pitch_z)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            flg_dl_reg[0] <= {arg_d.clamp, arg_d.neg};
            for (int k = 1; k < CORDIC_LAT; k++) begin
                flg_dl_reg[k] <= flg_dl_reg[k-1];
            end
        end
    end

    // rounding, clamping and pitch saturation
    always_comb begin
        logic signed [OW-1:0] p;
        p = to_out(pitch_z, OW'(11520));
        if (flg_dl_reg[CORDIC_LAT-1][1]) begin
            p = flg_dl_reg[CORDIC_LAT-1][0] ? -OW'(11520) : OW'(11520);
        end
        rnd_next.roll    = 16'(to_out(roll_z, OW'(23040)));
        rnd_next.yaw     = 16'(to_out(yaw_z, OW'(23040)));
        rnd_next.pitch   = 15'(p);
        rnd_next.clamped = flg_dl_reg[CORDIC_LAT-1][1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_valid_reg <= 1'b0;
        end else if (ce) begin
            rnd_valid_reg <= ang_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rnd_reg <= rnd_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_tready) begin
                out_reg       <= skid_reg;
                skid_full_reg <= 1'b0;
            end
        end else if (rnd_valid_reg) begin
            if (!m_tvalid_reg || m_tready) begin
                out_reg      <= rnd_reg;
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_reg      <= rnd_reg;
                skid_full_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg.yaw, out_reg.pitch, out_reg.roll};
    assign m_tuser  = out_reg.clamped;

    `QTE_ASSERT(a_skid_has_out, skid_full_reg |-> m_tvalid_reg, "skid full without output")
    `QTE_ASSERT(a_clamp_pitch, (m_tvalid && m_tuser[0]) |-> (m_tdata[30:16] == 15'h2D00 || m_tdata[30:16] == 15'h5300), "clamped pitch not at 90 degrees")
    `QTE_ASSERT(a_roll_range, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd23040 && $signed(m_tdata[15:0]) >= -16'sd23040), "roll out of range")
    `QTE_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!m_tvalid && s_tready), "output not idle after reset")

endmodule

// ===== tb/quaternion_to_euler_tb.sv =====
// ---------------------------------------------------------------------------
// quaternion_to_euler_tb
// self-checking stream testbench for the quaternion to euler angle pipeline
// ---------------------------------------------------------------------------
// Drives quaternions through the slave stream and predicts roll, pitch, yaw
// and the pitch saturation flag with a bit-exact integer cordic of its own.
// Results are checked in order against the predictions. The run steps
// through phases with no idling, random sender gaps, random receiver stalls
// and both together.
// ---------------------------------------------------------------------------
module quaternion_to_euler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qte_pkg::*;

    localparam longint ONE30     = 64'sd1 <<< 30;
    localparam longint ACC180    = 64'sd180 * 1048576;
    localparam int     STALL_MAX = 5000;

    typedef struct packed {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] yaw;
        logic        clamped;
    } angles_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // quat_x, quat_y, quat_z, quat_w
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // roll_angle, pitch_angle, yaw_angle, zero pad
    logic [0:0]  m_tuser;   // pitch_clamped

    logic [63:0] quat_queue [$];
    angles_t     angle_queue [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          stall_cycles;
    bit          timed_out;

    quaternion_to_euler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // atan2(y, x) in 2^-20 degree
    function automatic longint cordic_angle(longint x, longint y);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (y == 0) return (x < 0) ? ACC180 : 0;
        if (x < 0) begin
            acc = (y > 0) ? ACC180 : -ACC180;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < N_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                acc = acc + longint'(ATAN_TAB[i]);
            end else begin
                x = x - dx;
                y = y + dy;
                acc = acc - longint'(ATAN_TAB[i]);
            end
        end
        return acc;
    endfunction

    function automatic longint round_clip(longint acc, longint lim);
        longint v;
        v = (acc + 4096) >>> 13;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic angles_t euler_of(logic [63:0] d);
        longint qx, qy, qz, qw, sinr, cosr, sinp, siny, cosy, c, p;
        angles_t a;
        qx = longint'($signed(d[15:0]));
        qy = longint'($signed(d[31:16]));
        qz = longint'($signed(d[47:32]));
        qw = longint'($signed(d[63:48]));
        sinr = 2 * (qw * qx + qy * qz);
        cosr = ONE30 - 2 * (qx * qx + qy * qy);
        sinp = 2 * (qw * qy - qz * qx);
        siny = 2 * (qw * qz + qx * qy);
        cosy = ONE30 - 2 * (qy * qy + qz * qz);
        a.roll = 16'(round_clip(cordic_angle(cosr, sinr), 23040));
        a.yaw  = 16'(round_clip(cordic_angle(cosy, siny), 23040));
        a.clamped = 1'b0;
        if (sinp >= ONE30) begin
            p = 11520;
            a.clamped = 1'b1;
        end else if (sinp <= -ONE30) begin
            p = -11520;
            a.clamped = 1'b1;
        end else begin
            c = longint'(int_sqrt((64'd1 << 60) - longint'(sinp * sinp)));
            p = round_clip(cordic_angle(c, sinp), 11520);
        end
        a.pitch = 15'(p);
        return a;
    endfunction

    function automatic logic [63:0] pack_quat(int x, int y, int z, int w);
        return {16'(w), 16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic int rand_comp();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic logic [63:0] unit_quat();
        real v [4];
        real mag;
        int  q [4];
        mag = 0.0;
        while (mag < 1.0) begin
            mag = 0.0;
            for (int i = 0; i < 4; i++) begin
                v[i] = real'(rand_comp());
                mag = mag + v[i] * v[i];
            end
        end
        mag = $sqrt(mag);
        for (int i = 0; i < 4; i++) q[i] = $rtoi(v[i] / mag * 32767.0);
        return pack_quat(q[0], q[1], q[2], q[3]);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (quat_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= quat_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor and checker
    always @(posedge aclk) begin
        angles_t want;
        angles_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) angle_queue.push_back(euler_of(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[30:16], m_tdata[46:31], m_tuser[0]};
                if (angle_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: roll %0d pitch %0d yaw %0d clamp %0b",
                                 $signed(got.roll), $signed(got.pitch),
                                 $signed(got.yaw), got.clamped);
                end else begin
                    want = angle_queue.pop_front();
                    if (got !== want || m_tdata[47] !== 1'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "exp/act: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d clamp %0b/%0b",
                                $signed(want.roll), $signed(got.roll),
                                $signed(want.pitch), $signed(got.pitch),
                                $signed(want.yaw), $signed(got.yaw),
                                want.clamped, got.clamped);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (quat_queue.size() == 0 && angle_queue.size() == 0 && !s_tvalid))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) timed_out <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (timed_out) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int n;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        stall_cycles   = 0;
        timed_out      = 1'b0;

        // directed corners
        quat_queue.push_back(pack_quat(0, 0, 0, 0));
        quat_queue.push_back(pack_quat(0, 0, 0, 32767));
        quat_queue.push_back(pack_quat(0, 0, 0, -32768));
        quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
        quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
        quat_queue.push_back(pack_quat(32767, -32768, 32767, -32768));
        quat_queue.push_back(pack_quat(0, -32768, 0, -32768));
        quat_queue.push_back(pack_quat(0, 32767, 0, 32767));
        quat_queue.push_back(pack_quat(0, -32768, 0, 32767));
        quat_queue.push_back(pack_quat(0, 23170, 0, 23170));
        quat_queue.push_back(pack_quat(0, 23171, 0, 23171));
        quat_queue.push_back(pack_quat(0, -23171, 0, 23171));
        quat_queue.push_back(pack_quat(32767, 0, 0, 0));
        quat_queue.push_back(pack_quat(0, 0, 32767, 0));
        quat_queue.push_back(pack_quat(-32768, 0, 0, 0));
        quat_queue.push_back(pack_quat(32000, 0, 0, 5000));
        quat_queue.push_back(pack_quat(32000, 0, 0, -5000));
        quat_queue.push_back(pack_quat(0, 0, 32000, 5000));
        quat_queue.push_back(pack_quat(0, 0, 32000, -5000));
        quat_queue.push_back(pack_quat(23170, 0, 0, 23170));
        quat_queue.push_back(pack_quat(0, 0, 0, 1));
        quat_queue.push_back(pack_quat(1, 0, 0, 0));
        quat_queue.push_back(pack_quat(0, 1, 0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 27 : 0;
            recv_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 27 : 0;
            for (int k = 0; k < 210; k++) begin
                n = $urandom_range(0, 99);
                if (n < 65) begin
                    quat_queue.push_back(unit_quat());
                end else if (n < 75) begin
                    // pitch near gimbal lock
                    n = int'($urandom_range(23160, 23180));
                    quat_queue.push_back(pack_quat(int'($urandom_range(0, 3)) - 1,
                        ($urandom_range(0, 1) ? n : -n), int'($urandom_range(0, 3)) - 1,
                        ($urandom_range(0, 1) ? n : -n)));
                end else begin
                    quat_queue.push_back(pack_quat(rand_comp(), rand_comp(),
                                                   rand_comp(), rand_comp()));
                end
            end
            while (quat_queue.size() > 0 || s_tvalid) @(posedge aclk);
        end

        while (angle_queue.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && angle_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== quaternion_to_euler.f =====
+incdir+sv
sv/qte_pkg.sv
sv/qte_products.sv
sv/qte_isqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler.sv
tb/quaternion_to_euler_tb.sv
